@@ rtl/urtp_pkg.sv @@
// ----------------------------------------------------------------------------
// urtp_pkg
// Shared types and constants for the unicode-range token parser.
// ----------------------------------------------------------------------------
package urtp_pkg;

  localparam int CharWidth = 8;
  localparam int CpWidth   = 21;

  typedef logic [CharWidth-1:0] char_t;
  typedef logic [CpWidth-1:0]   cp_t;

  // Highest legal code point.
  localparam cp_t CP_MAX = 21'h10FFFF;

  localparam char_t CH_LOWER_U = 8'h75;  // 'u'
  localparam char_t CH_UPPER_U = 8'h55;  // 'U'
  localparam char_t CH_PLUS    = 8'h2B;  // '+'
  localparam char_t CH_DASH    = 8'h2D;  // '-'
  localparam char_t CH_QUEST   = 8'h3F;  // '?'
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_CR      = 8'h0D;

  localparam logic [3:0] NIBBLE_ALL_ONES = 4'hF;

  // One parsed range as it leaves the block.
  typedef struct packed {
    logic valid_res;
    cp_t  range_low;
    cp_t  range_high;
  } range_t;

endpackage

@@ rtl/urtp_char_if.sv @@
// ----------------------------------------------------------------------------
// urtp_char_if
// Valid/ready channel carrying one token byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface urtp_char_if;
  logic                valid;
  logic                ready;
  urtp_pkg::char_t     char_byte;
  logic                last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

@@ rtl/urtp_range_if.sv @@
// ----------------------------------------------------------------------------
// urtp_range_if
// Valid/ready channel carrying one parsed code point range.
// ----------------------------------------------------------------------------
interface urtp_range_if;
  logic          valid;
  logic          ready;
  logic          valid_res;
  urtp_pkg::cp_t range_low;
  urtp_pkg::cp_t range_high;

  modport source (output valid, output valid_res, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input valid_res, input range_low, input range_high,
                  output ready);
endinterface

@@ rtl/unicode_range_token_parser.sv @@
// ----------------------------------------------------------------------------
// unicode_range_token_parser
// Byte-serial parser for one CSS unicode-range token per segment.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on the chars channel, with last_char
// set on the final byte of a segment, and sends one result (valid_res,
// range_low, range_high) on the ranges channel for each segment. The byte
// is folded into the parser state in the cycle it is transferred, and on
// the last byte the finished range is computed in that same cycle and
// lands in the output register, or in the one-entry skid register behind
// it when a result already waits there. The skid keeps the input side
// running while a result waits; chars.ready drops only when both hold a
// result, so the sustained rate is one byte per clock while ranges keeps up.
module unicode_range_token_parser #(
  parameter int MAX_HEX_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  urtp_char_if.sink   chars,
  urtp_range_if.source ranges
);

  localparam int AW   = 4 * MAX_HEX_DIGITS;
  localparam int CW   = $clog2(MAX_HEX_DIGITS + 1);
  localparam int CMPW = (AW > urtp_pkg::CpWidth) ? AW : urtp_pkg::CpWidth;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_GOT_U = 2'd1;
  localparam logic [1:0] PH_START = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  localparam logic [CW-1:0] DIGITS_MAX = CW'(MAX_HEX_DIGITS);

  // Parser state.
  logic [1:0]    phase, phase_next;
  logic [AW-1:0] low_accum, low_accum_next;
  logic [AW-1:0] high_accum, high_accum_next;
  logic [AW-1:0] end_accum, end_accum_next;
  logic [CW-1:0] start_cnt, start_cnt_next;
  logic [CW-1:0] end_cnt, end_cnt_next;
  logic          wildcard_seen, wildcard_seen_next;
  logic          trailing_seen, trailing_seen_next;
  logic          failed, failed_next;

  // Output register and skid register.
  logic                out_valid;
  urtp_pkg::range_t    out_data;
  logic                skid_valid;
  urtp_pkg::range_t    skid_data;
  urtp_pkg::range_t    result;

  logic accept;
  logic is_space;
  logic is_hex;
  logic [3:0] hex_val;
  logic ok;
  logic [CMPW-1:0] lo_x, hi_x;

  assign chars.ready = !skid_valid;
  assign accept      = chars.valid && chars.ready;

  always_comb begin
    is_space = (chars.char_byte == urtp_pkg::CH_SPACE) ||
               ((chars.char_byte >= urtp_pkg::CH_TAB) && (chars.char_byte <= urtp_pkg::CH_CR));
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (chars.char_byte >= 8'h30 && chars.char_byte <= 8'h39) begin
      hex_val = chars.char_byte[3:0];
    end else if ((chars.char_byte >= 8'h61 && chars.char_byte <= 8'h66) ||
                 (chars.char_byte >= 8'h41 && chars.char_byte <= 8'h46)) begin
      hex_val = chars.char_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Fold one byte into the parser state.
  always_comb begin
    phase_next         = phase;
    low_accum_next     = low_accum;
    high_accum_next    = high_accum;
    end_accum_next     = end_accum;
    start_cnt_next     = start_cnt;
    end_cnt_next       = end_cnt;
    wildcard_seen_next = wildcard_seen;
    trailing_seen_next = trailing_seen;
    failed_next        = failed;
    if (!failed) begin
      if (is_space) begin
        if (phase != PH_LEAD) begin
          trailing_seen_next = 1'b1;
        end
      end else if (trailing_seen) begin
        failed_next = 1'b1;
      end else begin
        case (phase)
          PH_LEAD: begin
            if (chars.char_byte == urtp_pkg::CH_LOWER_U ||
                chars.char_byte == urtp_pkg::CH_UPPER_U) begin
              phase_next = PH_GOT_U;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_GOT_U: begin
            if (chars.char_byte == urtp_pkg::CH_PLUS) begin
              phase_next = PH_START;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_START: begin
            if (chars.char_byte == urtp_pkg::CH_DASH) begin
              if (wildcard_seen || start_cnt == '0) begin
                failed_next = 1'b1;
              end else begin
                phase_next = PH_END;
              end
            end else if (start_cnt >= DIGITS_MAX) begin
              failed_next = 1'b1;
            end else if (is_hex) begin
              if (wildcard_seen) begin
                failed_next = 1'b1;
              end else begin
                low_accum_next  = (low_accum << 4) | AW'(hex_val);
                high_accum_next = (high_accum << 4) | AW'(hex_val);
                start_cnt_next  = start_cnt + CW'(1);
              end
            end else if (chars.char_byte == urtp_pkg::CH_QUEST) begin
              // A wildcard is 0 in the low bound and F in the high bound.
              wildcard_seen_next = 1'b1;
              low_accum_next     = low_accum << 4;
              high_accum_next    = (high_accum << 4) | AW'(urtp_pkg::NIBBLE_ALL_ONES);
              start_cnt_next     = start_cnt + CW'(1);
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_END: begin
            if (is_hex && end_cnt < DIGITS_MAX) begin
              end_accum_next = (end_accum << 4) | AW'(hex_val);
              end_cnt_next   = end_cnt + CW'(1);
            end else begin
              failed_next = 1'b1;
            end
          end
          default: begin
            failed_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Finish the range from the updated state.
  always_comb begin
    ok   = 1'b0;
    lo_x = '0;
    hi_x = '0;
    if (!failed_next && phase_next == PH_START && start_cnt_next != '0) begin
      ok   = 1'b1;
      lo_x = CMPW'(low_accum_next);
      hi_x = CMPW'(high_accum_next);
    end else if (!failed_next && phase_next == PH_END && end_cnt_next != '0) begin
      ok   = 1'b1;
      lo_x = CMPW'(low_accum_next);
      hi_x = CMPW'(end_accum_next);
    end
    if (ok && (lo_x > hi_x || lo_x > CMPW'(urtp_pkg::CP_MAX))) begin
      ok = 1'b0;
    end
    if (ok && hi_x > CMPW'(urtp_pkg::CP_MAX)) begin
      hi_x = CMPW'(urtp_pkg::CP_MAX);
    end
    if (!ok) begin
      lo_x = '0;
      hi_x = '0;
    end
    result.valid_res  = ok;
    result.range_low  = lo_x[urtp_pkg::CpWidth-1:0];
    result.range_high = hi_x[urtp_pkg::CpWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      low_accum     <= '0;
      high_accum    <= '0;
      end_accum     <= '0;
      start_cnt     <= '0;
      end_cnt       <= '0;
      wildcard_seen <= 1'b0;
      trailing_seen <= 1'b0;
      failed        <= 1'b0;
    end else if (accept) begin
      if (chars.last_char) begin
        // The segment is done: start the next token from scratch.
        phase         <= PH_LEAD;
        low_accum     <= '0;
        high_accum    <= '0;
        end_accum     <= '0;
        start_cnt     <= '0;
        end_cnt       <= '0;
        wildcard_seen <= 1'b0;
        trailing_seen <= 1'b0;
        failed        <= 1'b0;
      end else begin
        phase         <= phase_next;
        low_accum     <= low_accum_next;
        high_accum    <= high_accum_next;
        end_accum     <= end_accum_next;
        start_cnt     <= start_cnt_next;
        end_cnt       <= end_cnt_next;
        wildcard_seen <= wildcard_seen_next;
        trailing_seen <= trailing_seen_next;
        failed        <= failed_next;
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !ranges.ready) begin
        if (accept && chars.last_char) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && chars.last_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !ranges.ready) begin
      if (accept && chars.last_char) begin
        skid_data <= result;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (accept && chars.last_char) begin
      out_data <= result;
    end
  end

  assign ranges.valid      = out_valid;
  assign ranges.valid_res  = out_data.valid_res;
  assign ranges.range_low  = out_data.range_low;
  assign ranges.range_high = out_data.range_high;

  // The skid entry only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // A last byte transferred while the output stalls must land in the skid entry.
  a_last_into_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.last_char && out_valid && !ranges.ready) |=> skid_valid)
    else $error("result of a stalled segment was dropped");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.valid_res) |->
      (out_data.range_low == '0 && out_data.range_high == '0))
    else $error("invalid range carries nonzero bounds");

  a_valid_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.valid_res) |->
      (out_data.range_low <= out_data.range_high &&
       out_data.range_high <= urtp_pkg::CP_MAX))
    else $error("valid range is out of order or above the code point limit");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unicode-range token parser.
// ----------------------------------------------------------------------------
// Tokens are sent a byte per transfer. A few hand-picked tokens come first,
// then random ones: mostly well-formed single points, wildcard ranges and
// dash ranges with random digits, mixed with mutated tokens and junk. Each
// accepted byte is folded into a local parser copy, and every finished
// token queues the range it should produce. Each range that leaves the
// block is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MaxDigits  = 6;
  localparam int CycleLimit = 300000;

  typedef enum logic [1:0] {SCAN_LEAD, SCAN_SIGN, SCAN_FIRST, SCAN_LAST} scan_t;

  typedef struct {
    urtp_pkg::char_t ch;
    logic            last;
    bit              drain;  // hold this byte back until every owed range has come
  } char_xfer_t;

  logic clk = 1'b0;
  logic rst;

  urtp_char_if  chars ();
  urtp_range_if ranges ();

  unicode_range_token_parser #(.MAX_HEX_DIGITS(MaxDigits)) uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .ranges (ranges)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  char_xfer_t        pending[$];
  urtp_pkg::range_t  ranges_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_taken = 0;
  int unsigned ranges_owed = 0;
  int unsigned ranges_seen = 0;
  int unsigned hold_left;
  bit          hold_armed;
  int          burst_left;
  int          gap_left;
  int          stall_mode;

  // Local copy of the parser state.
  scan_t       scan;
  logic [23:0] lo_acc, hi_acc, end_acc;
  int unsigned first_digits, last_digits;
  bit          wild, tail_space, broken;

  task automatic report(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic bit is_blank(input urtp_pkg::char_t c);
    return c == urtp_pkg::CH_SPACE || (c >= urtp_pkg::CH_TAB && c <= urtp_pkg::CH_CR);
  endfunction

  function automatic int nibble_of(input urtp_pkg::char_t c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic urtp_pkg::char_t hex_char(input int v);
    if (v < 10) return urtp_pkg::char_t'(int'("0") + v);
    if ($urandom_range(0, 1) == 1) return urtp_pkg::char_t'(int'("a") + v - 10);
    return urtp_pkg::char_t'(int'("A") + v - 10);
  endfunction

  function automatic urtp_pkg::char_t blank_char();
    int w;
    w = $urandom_range(8, 13);
    return (w == 8) ? urtp_pkg::CH_SPACE : urtp_pkg::char_t'(w);
  endfunction

  function automatic void clear_scan();
    scan = SCAN_LEAD;
    lo_acc = '0;
    hi_acc = '0;
    end_acc = '0;
    first_digits = 0;
    last_digits = 0;
    wild = 1'b0;
    tail_space = 1'b0;
    broken = 1'b0;
  endfunction

  // Folds one accepted byte into the local parser; a last byte queues a range.
  function automatic void fold_char(input urtp_pkg::char_t c, input logic last);
    int               hv;
    bit               ok;
    logic [23:0]      lo, hi;
    urtp_pkg::range_t r;
    hv = nibble_of(c);
    if (!broken) begin
      if (is_blank(c)) begin
        if (scan != SCAN_LEAD) tail_space = 1'b1;
      end else if (tail_space) begin
        broken = 1'b1;
      end else begin
        case (scan)
          SCAN_LEAD: begin
            if (c == urtp_pkg::CH_LOWER_U || c == urtp_pkg::CH_UPPER_U) scan = SCAN_SIGN;
            else broken = 1'b1;
          end
          SCAN_SIGN: begin
            if (c == urtp_pkg::CH_PLUS) scan = SCAN_FIRST;
            else broken = 1'b1;
          end
          SCAN_FIRST: begin
            if (c == urtp_pkg::CH_DASH) begin
              if (wild || first_digits == 0) broken = 1'b1;
              else scan = SCAN_LAST;
            end else if (first_digits >= MaxDigits) begin
              broken = 1'b1;
            end else if (hv >= 0) begin
              if (wild) begin
                broken = 1'b1;
              end else begin
                lo_acc = {lo_acc[19:0], hv[3:0]};
                hi_acc = {hi_acc[19:0], hv[3:0]};
                first_digits++;
              end
            end else if (c == urtp_pkg::CH_QUEST) begin
              wild = 1'b1;
              lo_acc = {lo_acc[19:0], 4'h0};
              hi_acc = {hi_acc[19:0], urtp_pkg::NIBBLE_ALL_ONES};
              first_digits++;
            end else begin
              broken = 1'b1;
            end
          end
          default: begin
            if (hv >= 0 && last_digits < MaxDigits) begin
              end_acc = {end_acc[19:0], hv[3:0]};
              last_digits++;
            end else begin
              broken = 1'b1;
            end
          end
        endcase
      end
    end
    if (last) begin
      ok = !broken;
      lo = '0;
      hi = '0;
      if (ok && scan == SCAN_FIRST && first_digits > 0) begin
        lo = lo_acc;
        hi = hi_acc;
      end else if (ok && scan == SCAN_LAST && last_digits > 0) begin
        lo = lo_acc;
        hi = end_acc;
      end else begin
        ok = 1'b0;
      end
      if (ok && (lo > 24'(urtp_pkg::CP_MAX) || lo > hi)) ok = 1'b0;
      if (ok && hi > 24'(urtp_pkg::CP_MAX)) hi = 24'(urtp_pkg::CP_MAX);
      r.valid_res  = ok;
      r.range_low  = ok ? lo[urtp_pkg::CpWidth-1:0] : '0;
      r.range_high = ok ? hi[urtp_pkg::CpWidth-1:0] : '0;
      ranges_due.push_back(r);
      clear_scan();
    end
  endfunction

  task automatic push_token(input urtp_pkg::char_t tok[$], input bit drain);
    char_xfer_t x;
    for (int i = 0; i < tok.size(); i++) begin
      x.ch = tok[i];
      x.last = (i == tok.size() - 1);
      x.drain = drain && (i == 0);
      pending.push_back(x);
    end
  endtask

  task automatic add_text(input string s, input bit drain);
    urtp_pkg::char_t q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    push_token(q, drain);
  endtask

  // Six-digit numbers mostly lead with 0 or 1 so that many stay in range.
  task automatic add_number(ref urtp_pkg::char_t q[$], input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && n == MaxDigits && $urandom_range(0, 1) == 1)
        q.push_back(hex_char($urandom_range(0, 1)));
      else
        q.push_back(hex_char($urandom_range(0, 15)));
    end
  endtask

  // Sender: bursts of transfers with random gaps between them.
  always @(posedge clk) begin
    char_xfer_t nxt;
    bit         took_last;
    if (rst) begin
      chars.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      clear_scan();
    end else begin
      took_last = 1'b0;
      if (chars.valid && chars.ready) begin
        fold_char(chars.char_byte, chars.last_char);
        bytes_taken <= bytes_taken + 1;
        if (chars.last_char) begin
          ranges_owed <= ranges_owed + 1;
          took_last = 1'b1;
        end
      end
      if (!chars.valid || chars.ready) begin
        if (gap_left > 0) begin
          chars.valid <= 1'b0;
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && (took_last || ranges_owed != ranges_seen))) begin
          nxt = pending.pop_front();
          chars.valid <= 1'b1;
          chars.char_byte <= nxt.ch;
          chars.last_char <= nxt.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && bytes_taken >= 700) begin
      hold_left <= 150;
      hold_armed <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: its own stall pattern, changed every so often.
  always @(posedge clk) begin
    bit rdy;
    if (rst) begin
      ranges.ready <= 1'b0;
      stall_mode = 0;
    end else begin
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        2: rdy = (cycles % 4 == 0);
        default: rdy = ($urandom_range(0, 4) != 0);
      endcase
      ranges.ready <= rdy && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    urtp_pkg::range_t want;
    if (!rst && ranges.valid && ranges.ready) begin
      ranges_seen <= ranges_seen + 1;
      if (ranges_due.size() == 0) begin
        report("range transfer with none expected");
      end else begin
        want = ranges_due.pop_front();
        if (ranges.valid_res !== want.valid_res)
          report($sformatf("valid_res %b, expected %b", ranges.valid_res, want.valid_res));
        if (ranges.range_low !== want.range_low)
          report($sformatf("range_low %h, expected %h", ranges.range_low, want.range_low));
        if (ranges.range_high !== want.range_high)
          report($sformatf("range_high %h, expected %h", ranges.range_high, want.range_high));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    urtp_pkg::char_t tok[$];
    int              n, k, m, pos, ntok;
    rst = 1'b1;

    add_text(" ", 1'b0);
    add_text("\tU+fF\v", 1'b0);
    add_text("u+1?????", 1'b0);
    add_text("u+A-9", 1'b1);
    add_text("u+0-10ffff", 1'b0);
    add_text("U+?a", 1'b0);
    add_text("u+5-", 1'b0);
    tok = {urtp_pkg::CH_LOWER_U, 8'hFF};
    push_token(tok, 1'b0);

    ntok = 0;
    while (pending.size() < 1990) begin
      tok.delete();
      if ($urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(1, 3)) tok.push_back(blank_char());
      end else if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 8)) tok.push_back(urtp_pkg::char_t'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) tok.push_back(blank_char());
        tok.push_back(($urandom_range(0, 1) == 1) ? urtp_pkg::CH_LOWER_U : urtp_pkg::CH_UPPER_U);
        tok.push_back(urtp_pkg::CH_PLUS);
        case ($urandom_range(0, 2))
          0: add_number(tok, $urandom_range(1, MaxDigits));
          1: begin
            k = $urandom_range(0, MaxDigits - 1);
            m = $urandom_range(1, MaxDigits - k);
            add_number(tok, k);
            repeat (m) tok.push_back(urtp_pkg::CH_QUEST);
          end
          default: begin
            add_number(tok, $urandom_range(1, MaxDigits));
            tok.push_back(urtp_pkg::CH_DASH);
            add_number(tok, $urandom_range(1, MaxDigits));
          end
        endcase
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) tok.push_back(blank_char());
        // Break about one token in five.
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, tok.size() - 1);
          case ($urandom_range(0, 3))
            0: tok[pos] = urtp_pkg::char_t'($urandom_range(0, 255));
            1: begin
              n = $urandom_range(0, 4);
              tok.insert(pos, (n == 0) ? urtp_pkg::CH_DASH : (n == 1) ? urtp_pkg::CH_QUEST :
                              (n == 2) ? urtp_pkg::CH_PLUS : (n == 3) ? urtp_pkg::CH_SPACE :
                              hex_char($urandom_range(0, 15)));
            end
            2: if (tok.size() > 1) tok.delete(pos);
            default: tok.push_back(hex_char($urandom_range(0, 15)));
          endcase
        end
      end
      push_token(tok, ntok == 120 || ntok == 260);
      ntok++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || chars.valid || ranges_owed != ranges_seen)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (ranges_due.size() != 0)
      report($sformatf("%0d expected ranges never arrived", ranges_due.size()));
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
